// File: hdl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types for the timer tick table
// command and expiry word layouts, command codes and result limit
// ----------------------------------------------------------------------------
package mtt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_code_t;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    cmd_code_t   cmd;
    logic [3:0]  timer_index;
    logic [7:0]  event_code;
    logic [5:0]  target_id;
    logic [15:0] initial_ticks;
    logic [15:0] period_ticks;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0] expired_timer;
    logic [5:0] expired_target;
    logic [7:0] expired_event;
    logic       last_expiry;
  } exp_word_t;

endpackage

// File: hdl/multi_timer_tick_table.sv
// ----------------------------------------------------------------------------
// multi_timer_tick_table: table of one-shot and periodic timers
// a sequencer walks the ram one entry per cycle, unless stalled, on every tick
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd_word): tick,
// init, start or stop. A word is taken when cmd_valid is high and cmd_stall
// is low; cmd_stall stays high while a command is being worked on.
// Init, start and stop do a read-modify-write of one ram entry: the read is
// issued in S_IDLE and the write done in S_CMD. A command whose index is
// beyond the table is dropped without leaving S_IDLE. A tick reads every
// entry in turn, one per cycle through the single ram port pair while the
// expiry channel does not stall; armed ones are decremented or reloaded.
// Each expiring timer, up to MAX_RESULTS per tick, gives one word on the exp
// channel (exp_valid, exp_stall, exp_word), in ascending timer order; the
// last word of a tick has last_expiry set. One expiry is held back until
// the next one is found or the walk ends, so it can be marked last. While
// exp_stall holds the output register full, the walk pauses at the next
// expiry that has to be sent and resumes when the word is taken.
// Reset (rst, synchronous) clears the per-entry valid bits, so every timer
// reads as zero and disarmed; no clearing pass over the ram is needed.
// ----------------------------------------------------------------------------
module multi_timer_tick_table #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mtt_pkg::cmd_word_t cmd_word,
  output logic               exp_valid,
  input  logic               exp_stall,
  output mtt_pkg::exp_word_t exp_word
);

  import mtt_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_TIMERS - 1);

  typedef struct packed {
    logic [TICK_WIDTH-1:0] rem;
    logic [TICK_WIDTH-1:0] per;
    logic [7:0]            ev;
    logic [5:0]            tgt;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                state, state_next;
  logic [AW-1:0]         cur_addr, cur_addr_next;
  logic [NUM_TIMERS-1:0] valid_bits, valid_bits_next;
  cmd_word_t             cmd_reg, cmd_reg_next;
  exp_word_t             held, held_next;
  logic                  held_valid, held_valid_next;
  logic [CNT_W-1:0]      rep_cnt, rep_cnt_next;
  exp_word_t             out_word, out_word_next;
  logic                  out_valid, out_valid_next;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr;
  entry_t                rd_data, ent, wr_data;
  logic [TICK_WIDTH-1:0] dec, itick;
  logic                  armed, expire, reporting, blocked, out_free, push;
  exp_word_t             push_word;

  mtt_ram #(
    .WIDTH  ($bits(entry_t)),
    .DEPTH  (NUM_TIMERS),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_stall = (state != S_IDLE);
  assign exp_valid = out_valid;
  assign exp_word  = out_word;

  always_comb begin
    ent       = valid_bits[cur_addr] ? rd_data : '0;
    dec       = ent.rem - TICK_WIDTH'(1);
    armed     = (ent.rem != '0);
    expire    = armed && (dec == '0);
    reporting = expire && (rep_cnt < CNT_W'(MAX_RESULTS));
    out_free  = !out_valid || !exp_stall;
    blocked   = reporting && held_valid && !out_free;
    itick     = TICK_WIDTH'(cmd_reg.initial_ticks);

    state_next      = state;
    cur_addr_next   = cur_addr;
    valid_bits_next = valid_bits;
    cmd_reg_next    = cmd_reg;
    held_next       = held;
    held_valid_next = held_valid;
    rep_cnt_next    = rep_cnt;
    rd_en           = 1'b0;
    rd_addr         = cur_addr + AW'(1);
    wr_en           = 1'b0;
    wr_data         = ent;
    push            = 1'b0;
    push_word       = held;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_reg_next = cmd_word;
          if (cmd_word.cmd == CMD_TICK) begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            rep_cnt_next = '0;
            state_next   = S_SCAN;
          end else if (int'(cmd_word.timer_index) < NUM_TIMERS) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(cmd_word.timer_index);
            state_next = S_CMD;
          end
        end
      end
      S_CMD: begin
        wr_en = 1'b1;
        valid_bits_next[cur_addr] = 1'b1;
        case (cmd_reg.cmd)
          CMD_INIT: begin
            wr_data.ev  = cmd_reg.event_code;
            wr_data.rem = '0;
          end
          CMD_START: begin
            if (itick == '0) begin
              wr_data.rem = '0;
            end else begin
              wr_data.tgt = cmd_reg.target_id;
              wr_data.per = TICK_WIDTH'(cmd_reg.period_ticks);
              wr_data.rem = itick;
            end
          end
          default: begin
            wr_data.rem = '0;
          end
        endcase
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (!blocked) begin
          if (armed) begin
            wr_en       = 1'b1;
            wr_data.rem = expire ? ent.per : dec;
            valid_bits_next[cur_addr] = 1'b1;
          end
          if (reporting) begin
            push      = held_valid;
            push_word = held;
            held_next = '{expired_timer:  4'(cur_addr),
                          expired_target: ent.tgt,
                          expired_event:  ent.ev,
                          last_expiry:    1'b0};
            held_valid_next = 1'b1;
            rep_cnt_next    = rep_cnt + CNT_W'(1);
          end
          if (cur_addr == LAST_ADDR) begin
            state_next = S_FLUSH;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!held_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push                  = 1'b1;
          push_word             = held;
          push_word.last_expiry = 1'b1;
          held_valid_next       = 1'b0;
          state_next            = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (rd_en) begin
      cur_addr_next = rd_addr;
    end

    out_word_next  = out_word;
    out_valid_next = out_valid;
    if (push) begin
      out_valid_next = 1'b1;
      out_word_next  = push_word;
    end else if (!exp_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_reg  <= cmd_reg_next;
    held     <= held_next;
    out_word <= out_word_next;
    if (rst) begin
      state      <= S_IDLE;
      cur_addr   <= '0;
      valid_bits <= '0;
      held_valid <= 1'b0;
      rep_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_addr   <= cur_addr_next;
      valid_bits <= valid_bits_next;
      held_valid <= held_valid_next;
      rep_cnt    <= rep_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  // no expiry may be left behind once the table is idle again
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("held expiry left over in idle");

  // ram writes only come from a command or the tick walk
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CMD || state == S_SCAN))
    else $error("ram write outside command or walk");

  a_report_limit: assert property (@(posedge clk) disable iff (rst)
    rep_cnt <= CNT_W'(MAX_RESULTS))
    else $error("expiry count above limit");

  // the word marked last ends the tick
  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (push && push_word.last_expiry) |=> (state == S_IDLE && !held_valid))
    else $error("walk continues after last expiry");

  // a word is never dropped: pushing needs a free output register
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("expiry pushed over a stalled word");

endmodule

// File: hdl/mtt_ram.sv
// ----------------------------------------------------------------------------
// mtt_ram: generic simple dual-port ram
// one write port, one read port with registered read data held when idle
// ----------------------------------------------------------------------------
module mtt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
